>>> design/bust_pkg.sv
// Package for the bounded unique set table.
// Holds the default capacity and the operation and status codes.
// Used by bounded_unique_set_table; depends on nothing else.
package bust_pkg;

   // Default number of key slots in the table.
   localparam int DefaultCapacity = 16;

   // Operation codes carried by an input beat.
   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_FIND   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // Status codes returned with every result beat.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_DUPLICATE = 3'd2,
      STATUS_EMPTY     = 3'd3,
      STATUS_NOTFOUND  = 3'd4
   } status_type;

endpackage

>>> design/bounded_unique_set_table.sv
// Bounded unique set table: packed store of unique 32-bit keys with add, remove, find.
// A full, empty-remove, unused-kind or empty-table beat answers in the cycle after start;
// any other beat scans the stored keys, one memory read a cycle, and then answers.
// A scanned beat keeps the block busy until its result; trivial beats go one per cycle while idle;
// busy is high only during the scan, and results cannot stall.
// Reset clears the key count and control state; the key memory is not cleared and needs no sweep.
// Depends on bust_pkg.
module bounded_unique_set_table
   import bust_pkg::*;
#(
   parameter int CAPACITY = DefaultCapacity
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_key,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic               rsp_found,
   output logic [4:0]         rsp_occupancy
);

   localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [CntW-1:0]     count_ff, count_in;
   kind_type            kind_ff, kind_in;
   logic [31:0]         key_ff, key_in;
   logic [CntW-1:0]     rd_addr_ff, rd_addr_in;
   logic                pend_ff, pend_in;
   logic [IdxW-1:0]     pend_idx_ff, pend_idx_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [4:0]          rsp_occ_ff, rsp_occ_in;

   // Key memory with registered read data.
   logic [31:0]         mem [CAPACITY];
   logic [31:0]         mem_q_ff;
   logic                rd_en;
   logic                wr_en;
   logic [IdxW-1:0]     wr_addr;
   logic [31:0]         wr_data;

   logic                accept;
   logic                match_now;
   logic                hit_any;
   logic                last_beat;
   logic [CntW-1:0]     count_dec;

   assign accept    = start && (state_ff == S_IDLE);
   assign match_now = pend_ff && (mem_q_ff == key_ff);
   assign hit_any   = hit_ff || match_now;
   assign count_dec = count_ff - CntW'(1);
   assign last_beat = pend_ff && (CntW'(pend_idx_ff) == count_dec);
   assign rd_en     = (state_ff == S_SCAN) && (rd_addr_ff < count_ff);

   // Sequencer: decide trivial beats at once, otherwise scan, and compact on a removal.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      rd_addr_in    = rd_addr_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IdxW-1:0];
      wr_data       = key_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in       = kind_type'(req_kind);
               key_in        = req_key;
               rd_addr_in    = '0;
               hit_in        = 1'b0;
               rsp_status_in = STATUS_OK;
               rsp_found_in  = 1'b0;
               rsp_occ_in    = 5'(count_ff);
               priority if (kind_type'(req_kind) == KIND_NONE) begin
                  rsp_valid_in = 1'b1;
               end else if (kind_type'(req_kind) == KIND_ADD &&
                            count_ff >= CntW'(CAPACITY)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FULL;
               end else if (kind_type'(req_kind) == KIND_REMOVE && count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
               end else if (kind_type'(req_kind) == KIND_ADD && count_ff == '0) begin
                  // First key goes straight into slot zero.
                  wr_en        = 1'b1;
                  wr_addr      = '0;
                  wr_data      = req_key;
                  count_in     = CntW'(1);
                  rsp_valid_in = 1'b1;
                  rsp_occ_in   = 5'(CntW'(1));
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue the next read while the previous entry is compared.
            if (rd_en) begin
               rd_addr_in  = rd_addr_ff + CntW'(1);
               pend_in     = 1'b1;
               pend_idx_in = rd_addr_ff[IdxW-1:0];
            end
            if (match_now) begin
               hit_in = 1'b1;
            end
            // Once the key is found, every later entry moves down one slot.
            if (kind_ff == KIND_REMOVE && pend_ff && hit_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - IdxW'(1);
               wr_data = mem_q_ff;
            end
            if (last_beat) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               unique case (kind_ff)
                  KIND_ADD: begin
                     if (hit_any) begin
                        rsp_status_in = STATUS_DUPLICATE;
                     end else begin
                        wr_en      = 1'b1;
                        wr_addr    = count_ff[IdxW-1:0];
                        wr_data    = key_ff;
                        count_in   = count_ff + CntW'(1);
                        rsp_occ_in = 5'(count_ff + CntW'(1));
                     end
                  end
                  KIND_REMOVE: begin
                     if (hit_any) begin
                        count_in   = count_dec;
                        rsp_occ_in = 5'(count_dec);
                     end else begin
                        rsp_status_in = STATUS_NOTFOUND;
                     end
                  end
                  KIND_FIND: begin
                     rsp_found_in = hit_any;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      rd_addr_ff    <= rd_addr_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Key memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr_ff[IdxW-1:0]];
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // The count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY))
      else $error("key count above capacity");

   // An accepted beat either answers next cycle or starts a scan.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || state_ff == S_SCAN))
      else $error("accepted beat neither answered nor scanning");

   // A found flag only comes with an ok status.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_status_ff == STATUS_OK))
      else $error("found flag with error status");

   // A refused operation leaves the count untouched.
   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> $stable(count_ff))
      else $error("refused operation changed the count");

   // Compaction writes happen only while a removal scan is running.
   a_shift_in_remove: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && wr_en && !last_beat) |-> (kind_ff == KIND_REMOVE))
      else $error("memory write during a non-remove scan");

endmodule

>>> sim/bust_table_checker.sv
`timescale 1ns / 100ps
// Result checker for the bounded unique set table: keeps its own copy of the key
// store, predicts every result beat and compares it with what the block returns.
// Depends on bust_pkg.
module bust_table_checker
   import bust_pkg::*;
#(
   parameter int CAPACITY = DefaultCapacity
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_key,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_status,
   input  logic        rsp_found,
   input  logic [4:0]  rsp_occupancy,
   output int          fail_count,
   output int          replies_pending
);

   // One predicted result beat.
   typedef struct packed {
      status_type status;
      logic       found;
      logic [4:0] occupancy;
   } table_reply_type;

   // Shadow of the packed key store and its fill level.
   logic [31:0]     shadow_keys [CAPACITY];
   int              shadow_count = 0;
   table_reply_type expected_replies [$];
   int              failures = 0;

   // Returns the slot that holds the key, or the fill level when it is absent.
   function automatic int slot_of(logic [31:0] key);
      int i;
      for (i = 0; i < shadow_count; i++) begin
         if (shadow_keys[i] == key) return i;
      end
      return shadow_count;
   endfunction

   // Applies one operation to the shadow store and returns the result it yields.
   function automatic table_reply_type apply_operation(kind_type kind, logic [31:0] key);
      table_reply_type reply;
      int              pos;
      int              j;
      reply.status = STATUS_OK;
      reply.found  = 1'b0;
      unique case (kind)
         KIND_ADD: begin
            // Fullness is checked before duplication.
            if (shadow_count >= CAPACITY) begin
               reply.status = STATUS_FULL;
            end else if (slot_of(key) < shadow_count) begin
               reply.status = STATUS_DUPLICATE;
            end else begin
               shadow_keys[shadow_count] = key;
               shadow_count++;
            end
         end
         KIND_REMOVE: begin
            if (shadow_count == 0) begin
               reply.status = STATUS_EMPTY;
            end else begin
               pos = slot_of(key);
               if (pos >= shadow_count) begin
                  reply.status = STATUS_NOTFOUND;
               end else begin
                  // Close the gap so the store stays packed from slot zero.
                  for (j = pos; j + 1 < shadow_count; j++) begin
                     shadow_keys[j] = shadow_keys[j + 1];
                  end
                  shadow_count--;
               end
            end
         end
         KIND_FIND: begin
            reply.found = (slot_of(key) < shadow_count);
         end
         default: begin
         end
      endcase
      reply.occupancy = shadow_count[4:0];
      return reply;
   endfunction

   // Counts a failure and reports only the first few.
   task automatic note_failure(string what);
      if (failures < 10) $display("%0t ns: %s", $time, what);
      failures++;
   endtask

   // Compare result beats against the oldest prediction, then predict new beats.
   always @(posedge clock) begin : watch
      table_reply_type want;
      if (reset) begin
         shadow_count = 0;
         expected_replies.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               note_failure($sformatf({"result beat with none expected: ",
                                       "status %0d found %0b occupancy %0d"},
                                      rsp_status, rsp_found, rsp_occupancy));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status || rsp_found !== want.found ||
                   rsp_occupancy !== want.occupancy) begin
                  note_failure($sformatf({"result mismatch: expected status %0d found %0b ",
                                          "occupancy %0d, got status %0d found %0b ",
                                          "occupancy %0d"},
                                         want.status, want.found, want.occupancy,
                                         rsp_status, rsp_found, rsp_occupancy));
               end
            end
         end
         if (start && !busy) begin
            expected_replies.push_back(apply_operation(kind_type'(req_kind), req_key));
         end
      end
      fail_count      <= failures;
      replies_pending <= expected_replies.size();
   end

endmodule

>>> sim/tb_bounded_unique_set_table.sv
`timescale 1ns / 100ps
// Testbench top for the bounded unique set table: clock, reset, request stimulus,
// watchdog and verdict. Depends on bust_pkg, bust_table_checker and the block.
module tb_bounded_unique_set_table;
   import bust_pkg::*;

   localparam int RandomItems   = 1300;
   localparam int PhaseItems    = 100;
   localparam int PoolSize      = 20;
   localparam int WatchdogLimit = 1000;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic [1:0]         req_kind  = KIND_ADD;
   logic signed [31:0] req_key   = '0;
   logic               busy;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic               rsp_found;
   logic [4:0]         rsp_occupancy;
   int                 fail_count;
   int                 replies_pending;
   int                 idle_cycles = 0;
   bit                 gaps_on = 1'b1;
   logic [31:0]        key_pool [PoolSize];

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bounded_unique_set_table dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_found     (rsp_found),
      .rsp_occupancy (rsp_occupancy)
   );

   bust_table_checker table_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_occupancy   (rsp_occupancy),
      .fail_count      (fail_count),
      .replies_pending (replies_pending)
   );

   // Watchdog: end the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("bounded_unique_set_table regression: fail");
         $finish;
      end
   end

   // Presents one request beat after a random gap and returns once it is taken.
   task automatic send_request(kind_type kind, logic [31:0] key);
      int gap;
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_kind <= kind;
      req_key  <= key;
      do @(posedge clock); while (busy);
   endtask

   // Refills the key pool; a few slots get the extreme values.
   task automatic refresh_pool();
      int i;
      for (i = 0; i < PoolSize; i++) begin
         case ($urandom_range(0, 11))
            0:       key_pool[i] = 32'h8000_0000;
            1:       key_pool[i] = 32'h7FFF_FFFF;
            2:       key_pool[i] = 32'h0000_0000;
            3:       key_pool[i] = 32'hFFFF_FFFF;
            default: key_pool[i] = $urandom;
         endcase
      end
   endtask

   // Mostly keys from the pool so that hits, duplicates and fullness happen often.
   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return key_pool[$urandom_range(0, PoolSize - 1)];
   endfunction

   initial begin
      int       sent;
      int       phase_left;
      int       mode;
      int       roll;
      kind_type kind;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: empty table, unused kind, key extremes, duplicates,
      // absent keys and removal from the front, middle and back.
      send_request(KIND_FIND,   32'h0000_0001);
      send_request(KIND_REMOVE, 32'h0000_0001);
      send_request(KIND_NONE,   32'hFFFF_FFFF);
      send_request(KIND_ADD,    32'h8000_0000);
      send_request(KIND_ADD,    32'h7FFF_FFFF);
      send_request(KIND_ADD,    32'h0000_0000);
      send_request(KIND_ADD,    32'hFFFF_FFFF);
      send_request(KIND_ADD,    32'h7FFF_FFFF);
      send_request(KIND_FIND,   32'h0000_0000);
      send_request(KIND_FIND,   32'h5555_5555);
      send_request(KIND_REMOVE, 32'hAAAA_AAAA);
      send_request(KIND_REMOVE, 32'h7FFF_FFFF);
      send_request(KIND_FIND,   32'h7FFF_FFFF);
      send_request(KIND_FIND,   32'hFFFF_FFFF);
      send_request(KIND_REMOVE, 32'h8000_0000);
      send_request(KIND_NONE,   32'h0000_0000);
      send_request(KIND_REMOVE, 32'hFFFF_FFFF);
      send_request(KIND_REMOVE, 32'h0000_0000);
      send_request(KIND_REMOVE, 32'h0000_0000);

      // Random phases that lean toward filling, draining or a balanced mix.
      sent       = 0;
      phase_left = 0;
      while (sent < RandomItems) begin
         if (phase_left == 0) begin
            mode       = $urandom_range(0, 2);
            gaps_on    = ($urandom_range(0, 3) != 0);
            phase_left = PhaseItems;
            refresh_pool();
         end
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            kind = KIND_NONE;
         end else begin
            roll = $urandom_range(0, 99);
            case (mode)
               0:       kind = (roll < 70) ? KIND_ADD : (roll < 85) ? KIND_REMOVE : KIND_FIND;
               1:       kind = (roll < 20) ? KIND_ADD : (roll < 75) ? KIND_REMOVE : KIND_FIND;
               default: kind = (roll < 40) ? KIND_ADD : (roll < 70) ? KIND_REMOVE : KIND_FIND;
            endcase
         end
         send_request(kind, pick_key());
         if (kind != KIND_NONE) begin
            sent++;
            phase_left--;
         end
      end
      start <= 1'b0;

      // Drain outstanding results, then watch a while longer for stray beats.
      @(posedge clock);
      while (replies_pending != 0) @(posedge clock);
      repeat (2 * DefaultCapacity + 8) @(posedge clock);

      if (fail_count == 0) begin
         $display("bounded_unique_set_table regression: pass");
      end else begin
         $display("bounded_unique_set_table regression: fail");
      end
      $finish;
   end

endmodule
